// ===== sv/drt_pkg.sv =====
`timescale 1ns / 1ps

package drt_pkg;

  localparam logic [1:0] ACT_POST    = 2'd0;
  localparam logic [1:0] ACT_FINISH  = 2'd1;
  localparam logic [1:0] ACT_RECLAIM = 2'd2;

  localparam logic [1:0] POST_OK   = 2'd0;
  localparam logic [1:0] POST_FULL = 2'd1;
  localparam logic [1:0] POST_STOP = 2'd2;
  localparam logic [1:0] POST_NONE = 2'd3;

  localparam logic [1:0] OUT_ERROR     = 2'd0;
  localparam logic [1:0] OUT_COMPLETED = 2'd1;
  localparam logic [1:0] OUT_CANCELED  = 2'd2;
  localparam logic [1:0] OUT_NONE      = 2'd3;

  localparam logic [1:0] CFG_STOPPING  = 2'd0;
  localparam logic [1:0] CFG_EXCEPTION = 2'd1;
  localparam logic [1:0] CFG_COMPLETED = 2'd2;

  localparam int FIELD_W  = 7;
  localparam int STATUS_W = 64;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POST,
    ST_FIN,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic post;
    logic finish;
    logic rd;
    logic advance;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] in_action;
    logic       reclaim_go;
    logic       out_free;
  } sts_t;

endpackage

// ===== sv/dma_descriptor_ring_tracker.sv =====
`timescale 1ns / 1ps
// path from input word to output word valid: post through POST then DONE, unknown action straight to DONE,
// finish through FIN then RD and CHK repeated while slots are reclaimed, reclaim through RD and CHK likewise, then DONE
// one item at a time; the reclaim scan reads one busy mark per RD and CHK step from the slot memory
// a new item can be taken from the cycle after the previous result is loaded into the output register
// reset: synchronous; a clearing pass over every slot zeroes the busy marks,
// no item is taken during it, config writes are taken at any time

module dma_descriptor_ring_tracker #(
  parameter int RING_SLOTS = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [drt_pkg::STATUS_W-1:0] cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // slot[6:0], status_word[70:7], read_pointer[77:71], zero pad
  input  logic [drt_pkg::IN_W-1:0]     s_tdata,
  // action[1:0]
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // post_code[1:0], posted_slot[8:2], entry_outcome[10:9], first_used_out[17:11],
  // used_count_out[24:18], zero pad
  output logic [drt_pkg::OUT_W-1:0]    m_tdata
);

  localparam int AW = $clog2(RING_SLOTS);

  drt_pkg::cmd_t cmd;
  drt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  drt_datapath #(
    .RING_SLOTS (RING_SLOTS),
    .AW         (AW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_post_or_finish: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == drt_pkg::POST_NONE || m_tdata[10:9] == drt_pkg::OUT_NONE))
    else $error("result reports both a post and a finish");

  a_refused_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != drt_pkg::POST_OK) |-> (m_tdata[8:2] == '0))
    else $error("refused post reports a slot");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output word overwritten before it was taken");
`endif

endmodule

// ===== sv/drt_ctrl.sv =====
`timescale 1ns / 1ps

module drt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  drt_pkg::sts_t sts,
  output drt_pkg::cmd_t cmd
);

  drt_pkg::state_t state;
  drt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      drt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = drt_pkg::ST_IDLE;
        end
      end
      drt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          case (sts.in_action)
            drt_pkg::ACT_POST:    state_next = drt_pkg::ST_POST;
            drt_pkg::ACT_FINISH:  state_next = drt_pkg::ST_FIN;
            drt_pkg::ACT_RECLAIM: state_next = drt_pkg::ST_RD;
            default:              state_next = drt_pkg::ST_DONE;
          endcase
        end
      end
      drt_pkg::ST_POST: begin
        cmd.post   = 1'b1;
        state_next = drt_pkg::ST_DONE;
      end
      drt_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = drt_pkg::ST_RD;
      end
      drt_pkg::ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = drt_pkg::ST_CHK;
      end
      drt_pkg::ST_CHK: begin
        if (sts.reclaim_go) begin
          cmd.advance = 1'b1;
          state_next  = drt_pkg::ST_RD;
        end else begin
          state_next = drt_pkg::ST_DONE;
        end
      end
      drt_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = drt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/drt_datapath.sv =====
`timescale 1ns / 1ps

module drt_datapath #(
  parameter int RING_SLOTS = 128,
  parameter int AW         = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [1:0]                   cfg_index,
  input  logic [drt_pkg::STATUS_W-1:0] cfg_data,
  input  logic [drt_pkg::IN_W-1:0]     s_tdata,
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [drt_pkg::OUT_W-1:0]    m_tdata,
  input  drt_pkg::cmd_t                cmd,
  output drt_pkg::sts_t                sts
);

  localparam int FW = drt_pkg::FIELD_W;

  logic                         engine_stopping;
  logic [drt_pkg::STATUS_W-1:0] exception_bits;
  logic [drt_pkg::STATUS_W-1:0] completed_bits;

  logic [AW-1:0] first_used;
  logic [AW-1:0] used_count;
  logic [AW-1:0] clr_cnt;

  logic [FW-1:0] slot_q;
  logic [FW-1:0] rp_q;
  logic [1:0]    code_q;
  logic [FW-1:0] posted_q;
  logic [1:0]    outcome_q;

  logic          busy_mem [RING_SLOTS];
  logic          rd_busy;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  logic [FW-1:0]                in_slot;
  logic [drt_pkg::STATUS_W-1:0] in_status;
  logic [FW-1:0]                in_rp;
  logic [1:0]                   in_outcome;

  logic [AW:0]      post_sum;
  logic [AW-1:0]    post_slot;
  logic             post_ok;
  logic [AW+FW-1:0] post_slot_ext;
  logic [AW+FW-1:0] slot_ext;
  logic [AW+FW-1:0] fu_ext;
  logic [AW+FW-1:0] uc_ext;
  logic [AW+FW-1:0] rp_ext;
  logic             slot_in_ring;

  assign in_slot   = s_tdata[FW-1:0];
  assign in_status = s_tdata[FW+drt_pkg::STATUS_W-1:FW];
  assign in_rp     = s_tdata[2*FW+drt_pkg::STATUS_W-1:FW+drt_pkg::STATUS_W];

  // status word classification, exception wins over completion
  always_comb begin
    if ((in_status & exception_bits) != '0) begin
      in_outcome = drt_pkg::OUT_ERROR;
    end else if ((in_status & completed_bits) != '0) begin
      in_outcome = drt_pkg::OUT_COMPLETED;
    end else begin
      in_outcome = drt_pkg::OUT_CANCELED;
    end
  end

  // claimed slot wraps at the ring size
  assign post_sum  = {1'b0, first_used} + {1'b0, used_count};
  assign post_slot = (post_sum >= (AW+1)'(RING_SLOTS)) ?
                     AW'(post_sum - (AW+1)'(RING_SLOTS)) : post_sum[AW-1:0];
  assign post_ok   = !engine_stopping && (used_count != AW'(RING_SLOTS - 1));

  assign post_slot_ext = {{FW{1'b0}}, post_slot};
  assign slot_ext      = {{AW{1'b0}}, slot_q};
  assign fu_ext        = {{FW{1'b0}}, first_used};
  assign uc_ext        = {{FW{1'b0}}, used_count};
  assign rp_ext        = {{AW{1'b0}}, rp_q};
  assign slot_in_ring  = slot_ext < (AW+FW)'(RING_SLOTS);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.post) begin
      mem_we    = post_ok;
      mem_waddr = post_slot;
      mem_wdata = 1'b1;
    end else if (cmd.finish) begin
      mem_we    = slot_in_ring;
      mem_waddr = slot_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_busy <= busy_mem[first_used];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      engine_stopping <= 1'b0;
      exception_bits  <= '0;
      completed_bits  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        drt_pkg::CFG_STOPPING:  engine_stopping <= cfg_data[0];
        drt_pkg::CFG_EXCEPTION: exception_bits  <= cfg_data;
        drt_pkg::CFG_COMPLETED: completed_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_used <= '0;
      used_count <= '0;
      clr_cnt    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.post && post_ok) begin
        used_count <= used_count + AW'(1);
      end
      if (cmd.advance) begin
        used_count <= used_count - AW'(1);
        first_used <= (first_used == AW'(RING_SLOTS - 1)) ? '0 : first_used + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_q    <= in_slot;
      rp_q      <= in_rp;
      code_q    <= drt_pkg::POST_NONE;
      posted_q  <= '0;
      outcome_q <= (s_tuser == drt_pkg::ACT_FINISH) ? in_outcome : drt_pkg::OUT_NONE;
    end
    if (cmd.post) begin
      if (engine_stopping) begin
        code_q <= drt_pkg::POST_STOP;
      end else if (!post_ok) begin
        code_q <= drt_pkg::POST_FULL;
      end else begin
        code_q   <= drt_pkg::POST_OK;
        posted_q <= post_slot_ext[FW-1:0];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {7'b0, uc_ext[FW-1:0], fu_ext[FW-1:0], outcome_q, posted_q, code_q};
    end
  end

  assign sts.clr_last   = (clr_cnt == AW'(RING_SLOTS - 1));
  assign sts.in_action  = s_tuser;
  assign sts.reclaim_go = (used_count != '0) && !rd_busy && (fu_ext != rp_ext);
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule
